>>> design/rtpa_pkg.sv
// ----------------------------------------------------------------------------
// RTP presentation time aligner package
// Shared constants, payload types, controller/datapath command and status
// structs, and the microsecond normalization helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtpa_pkg;

   localparam int STREAM_COUNT_DEF = 4;

   localparam logic [19:0] DEFAULT_RATE = 20'd9000;
   localparam logic [21:0] USEC_PER_SEC = 22'd1000000;
   localparam logic [21:0] TWO_SEC_USEC = 22'd2000000;

   localparam logic FUNC_FRAME = 1'b0;
   localparam logic FUNC_CLOSE = 1'b1;

   // Integer pass of the divider yields a 32-bit quotient; the fraction pass
   // yields the 20-bit microsecond part.
   localparam int INT_DIV_STEPS  = 32;
   localparam int FRAC_DIV_STEPS = 20;
   localparam int CNT_W          = 5;

   typedef struct packed {
      logic        func;
      logic [1:0]  stream_slot;
      logic        rtcp_synced;
      logic        is_video;
      logic [31:0] rtp_timestamp;
      logic [19:0] clock_rate;
      logic [31:0] from_sec;
      logic [19:0] from_usec;
      logic [31:0] wall_sec;
      logic [19:0] wall_usec;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] out_sec;
      logic [19:0] out_usec;
   } rsp_payload_type;

   typedef struct packed {
      logic load_req;
      logic close_slot;
      logic div_init_int;
      logic div_init_frac;
      logic div_step;
      logic mul_frac;
      logic calc_ref;
      logic calc_adjust;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic is_close;
      logic synced;
      logic take_master;
      logic seen;
      logic rsp_free;
   } sts_type;

   typedef struct packed {
      logic [1:0]  carry;
      logic [19:0] usec;
   } norm_type;

   // Splits a microsecond sum below three seconds into carry and remainder.
   function automatic norm_type norm_usec(input logic [21:0] value);
      norm_type n;
      if (value >= TWO_SEC_USEC) begin
         n.carry = 2'd2;
         n.usec  = 20'(value - TWO_SEC_USEC);
      end else if (value >= USEC_PER_SEC) begin
         n.carry = 2'd1;
         n.usec  = 20'(value - USEC_PER_SEC);
      end else begin
         n.carry = 2'd0;
         n.usec  = value[19:0];
      end
      return n;
   endfunction

endpackage

>>> design/rtpa_if.sv
// ----------------------------------------------------------------------------
// RTP presentation time aligner channels
// Valid/ready channels for frame events and aligned presentation times.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rtpa_req_if;
   import rtpa_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rtpa_rsp_if;
   import rtpa_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> design/rtp_presentation_time_aligner_core.sv
// ----------------------------------------------------------------------------
// RTP presentation time aligner core
// Steps: a pass-through frame, or one that keeps the master, passes the
// decision step and then the result step; a new master taken from the wall
// clock or the old adjustment adds the reference and adjustment steps; a new
// master derived from the RTP delta first adds the 32-step and 20-step passes
// of the shared divider. The result step waits until the result register is
// free. Flow: one event at a time; the next transfer is taken only after the
// result is registered. Close events give no result.
// Reset: synchronous; clears master, per-stream seen flags, result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtp_presentation_time_aligner_core #(
   parameter int STREAM_COUNT = rtpa_pkg::STREAM_COUNT_DEF
) (
   input logic         clock,
   input logic         reset,
   rtpa_req_if.sink    req_chan,
   rtpa_rsp_if.source  rsp_chan
);
   import rtpa_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    req_ready;

   assign req_chan.ready = req_ready;

   rtpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rtpa_datapath #(
      .STREAM_COUNT (STREAM_COUNT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_chan.payload),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload)
   );

endmodule

>>> design/rtpa_ctrl.sv
// ----------------------------------------------------------------------------
// RTP presentation time aligner controller
// Sequences one event through decision, division, reference, adjustment and
// result steps of the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtpa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rtpa_pkg::sts_type sts,
   output rtpa_pkg::cmd_type cmd
);
   import rtpa_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_DECIDE    = 3'd1;
   localparam logic [2:0] ST_DIV_INT   = 3'd2;
   localparam logic [2:0] ST_MUL       = 3'd3;
   localparam logic [2:0] ST_FRAC_INIT = 3'd4;
   localparam logic [2:0] ST_DIV_FRAC  = 3'd5;
   localparam logic [2:0] ST_REF       = 3'd6;
   localparam logic [2:0] ST_ADJUST    = 3'd7;
   localparam logic [2:0] ST_OUTPUT_N  = 3'd0;

   logic [2:0]       state_ff, state_in;
   logic             out_pending_ff, out_pending_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == ST_IDLE) && !out_pending_ff;

   always_comb begin
      state_in       = state_ff;
      out_pending_in = out_pending_ff;
      cnt_in         = cnt_ff;
      cmd            = '0;
      if (out_pending_ff) begin
         // Result step: waits until the result register can take the value.
         if (sts.rsp_free) begin
            cmd.commit     = 1'b1;
            out_pending_in = 1'b0;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cmd.load_req = 1'b1;
                  state_in     = ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               cnt_in = '0;
               if (!sts.in_range) begin
                  state_in = ST_IDLE;
               end else if (sts.is_close) begin
                  cmd.close_slot = 1'b1;
                  state_in       = ST_IDLE;
               end else if (!sts.synced || !sts.take_master) begin
                  state_in       = ST_IDLE;
                  out_pending_in = 1'b1;
               end else if (sts.seen) begin
                  cmd.div_init_int = 1'b1;
                  state_in         = ST_DIV_INT;
               end else begin
                  state_in = ST_REF;
               end
            end
            ST_DIV_INT: begin
               cmd.div_step = 1'b1;
               cnt_in       = cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(INT_DIV_STEPS - 1)) begin
                  state_in = ST_MUL;
               end
            end
            ST_MUL: begin
               cmd.mul_frac = 1'b1;
               state_in     = ST_FRAC_INIT;
            end
            ST_FRAC_INIT: begin
               cmd.div_init_frac = 1'b1;
               cnt_in            = '0;
               state_in          = ST_DIV_FRAC;
            end
            ST_DIV_FRAC: begin
               cmd.div_step = 1'b1;
               cnt_in       = cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(FRAC_DIV_STEPS - 1)) begin
                  state_in = ST_REF;
               end
            end
            ST_REF: begin
               cmd.calc_ref = 1'b1;
               state_in     = ST_ADJUST;
            end
            ST_ADJUST: begin
               cmd.calc_adjust = 1'b1;
               state_in        = ST_OUTPUT_N;
               out_pending_in  = 1'b1;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         out_pending_ff <= 1'b0;
         cnt_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         out_pending_ff <= out_pending_in;
         cnt_ff         <= cnt_in;
      end
   end

endmodule

>>> design/rtpa_datapath.sv
// ----------------------------------------------------------------------------
// RTP presentation time aligner datapath
// Per-stream history, master and adjustment registers, a shared radix-2
// divider for the RTP delta, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtpa_datapath #(
   parameter int STREAM_COUNT = rtpa_pkg::STREAM_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rtpa_pkg::cmd_type         cmd,
   output rtpa_pkg::sts_type         sts,
   input  rtpa_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rtpa_pkg::rsp_payload_type rsp_payload
);
   import rtpa_pkg::*;

   localparam int SLOT_W = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;

   req_payload_type   req_ff;

   logic              master_valid_ff, master_valid_in;
   logic              master_video_ff, master_video_in;
   logic [SLOT_W-1:0] master_idx_ff, master_idx_in;
   logic [31:0]       adj_sec_ff, adj_sec_in;
   logic [19:0]       adj_usec_ff, adj_usec_in;

   logic [31:0]       prev_rtp_ff  [STREAM_COUNT];
   logic [31:0]       prev_sec_ff  [STREAM_COUNT];
   logic [19:0]       prev_usec_ff [STREAM_COUNT];
   logic [STREAM_COUNT-1:0] seen_ff, seen_in;

   logic [19:0]       div_rem_ff, div_rem_in;
   logic [39:0]       div_dvd_ff, div_dvd_in;
   logic [31:0]       quo_ff;
   logic [39:0]       prod_ff;
   logic [31:0]       ref_sec_ff, ref_sec_in;
   logic [19:0]       ref_usec_ff, ref_usec_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   logic [SLOT_W-1:0] slot_idx;
   logic              in_range;
   logic [31:0]       prev_rtp;
   logic [31:0]       prev_sec;
   logic [19:0]       prev_usec;
   logic              seen;
   logic [19:0]       divisor;
   logic [31:0]       delta;
   logic [20:0]       trial;
   logic              trial_ge;
   logic [31:0]       ref_base;
   logic [21:0]       ref_usum;
   norm_type          ref_norm;
   logic [21:0]       adj_t;
   norm_type          adj_norm;
   norm_type          sum_norm;
   logic              repeat_rtp;

   assign slot_idx  = SLOT_W'(req_ff.stream_slot);
   assign in_range  = 32'(req_ff.stream_slot) < 32'(STREAM_COUNT);
   assign prev_rtp  = prev_rtp_ff[slot_idx];
   assign prev_sec  = prev_sec_ff[slot_idx];
   assign prev_usec = prev_usec_ff[slot_idx];
   assign seen      = seen_ff[slot_idx];

   assign repeat_rtp = seen && (req_ff.rtp_timestamp == prev_rtp);

   assign sts.in_range    = in_range;
   assign sts.is_close    = (req_ff.func == FUNC_CLOSE);
   assign sts.synced      = req_ff.rtcp_synced;
   assign sts.take_master = !master_valid_ff || (!master_video_ff && req_ff.is_video);
   assign sts.seen        = seen;
   assign sts.rsp_free    = !rsp_valid_ff || rsp_ready;

   // Divider: the integer pass divides the RTP delta by the clock rate, the
   // fraction pass divides remainder times one million by the same rate.
   assign divisor  = (req_ff.clock_rate == '0) ? DEFAULT_RATE : req_ff.clock_rate;
   assign delta    = (req_ff.rtp_timestamp >= prev_rtp) ?
                     (req_ff.rtp_timestamp - prev_rtp) : '0;
   assign trial    = {div_rem_ff, div_dvd_ff[39]};
   assign trial_ge = trial >= {1'b0, divisor};

   always_comb begin
      div_rem_in = div_rem_ff;
      div_dvd_in = div_dvd_ff;
      if (cmd.div_init_int) begin
         div_rem_in = '0;
         div_dvd_in = {delta, 8'd0};
      end else if (cmd.div_init_frac) begin
         div_rem_in = prod_ff[39:20];
         div_dvd_in = {prod_ff[19:0], 20'd0};
      end else if (cmd.div_step) begin
         div_rem_in = trial_ge ? 20'(trial - {1'b0, divisor}) : trial[19:0];
         div_dvd_in = {div_dvd_ff[38:0], trial_ge};
      end
   end

   // Reference time of a new master.
   always_comb begin
      if (seen) begin
         ref_base = quo_ff + prev_sec;
         ref_usum = 22'(div_dvd_ff[19:0]) + 22'(prev_usec);
      end else if (master_valid_ff) begin
         ref_base = adj_sec_ff + req_ff.from_sec;
         ref_usum = 22'(adj_usec_ff) + 22'(req_ff.from_usec);
      end else begin
         ref_base = req_ff.wall_sec;
         ref_usum = 22'(req_ff.wall_usec);
      end
      ref_norm    = norm_usec(ref_usum);
      ref_sec_in  = ref_base + 32'(ref_norm.carry);
      ref_usec_in = ref_norm.usec;
   end

   // Adjustment is reference minus incoming time; two seconds are borrowed so
   // the microsecond difference never goes negative.
   assign adj_t    = 22'(ref_usec_ff) + TWO_SEC_USEC - 22'(req_ff.from_usec);
   assign adj_norm = norm_usec(adj_t);
   assign sum_norm = norm_usec(22'(req_ff.from_usec) + 22'(adj_usec_ff));

   always_comb begin
      master_valid_in = master_valid_ff;
      master_video_in = master_video_ff;
      master_idx_in   = master_idx_ff;
      adj_sec_in      = adj_sec_ff;
      adj_usec_in     = adj_usec_ff;
      seen_in         = seen_ff;
      if (cmd.calc_adjust) begin
         master_valid_in = 1'b1;
         master_video_in = req_ff.is_video;
         master_idx_in   = slot_idx;
         adj_sec_in      = ref_sec_ff - req_ff.from_sec - 32'd2 + 32'(adj_norm.carry);
         adj_usec_in     = adj_norm.usec;
      end
      if (cmd.close_slot) begin
         seen_in[slot_idx] = 1'b0;
         if (master_valid_ff && (master_idx_ff == slot_idx)) begin
            master_valid_in = 1'b0;
         end
      end
      if (cmd.commit) begin
         seen_in[slot_idx] = 1'b1;
      end
   end

   always_comb begin
      if (!req_ff.rtcp_synced) begin
         rsp_in.out_sec  = req_ff.from_sec;
         rsp_in.out_usec = req_ff.from_usec;
      end else if (repeat_rtp) begin
         rsp_in.out_sec  = prev_sec;
         rsp_in.out_usec = prev_usec;
      end else begin
         rsp_in.out_sec  = req_ff.from_sec + adj_sec_ff + 32'(sum_norm.carry);
         rsp_in.out_usec = sum_norm.usec;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_valid_ff <= 1'b0;
         master_video_ff <= 1'b0;
         master_idx_ff   <= '0;
         adj_sec_ff      <= '0;
         adj_usec_ff     <= '0;
         seen_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         master_valid_ff <= master_valid_in;
         master_video_ff <= master_video_in;
         master_idx_ff   <= master_idx_in;
         adj_sec_ff      <= adj_sec_in;
         adj_usec_ff     <= adj_usec_in;
         seen_ff         <= seen_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_payload;
      end
      div_rem_ff <= div_rem_in;
      div_dvd_ff <= div_dvd_in;
      if (cmd.mul_frac) begin
         quo_ff  <= div_dvd_ff[31:0];
         prod_ff <= {20'd0, div_rem_ff} * 40'(USEC_PER_SEC);
      end
      if (cmd.calc_ref) begin
         ref_sec_ff  <= ref_sec_in;
         ref_usec_ff <= ref_usec_in;
      end
      if (cmd.commit) begin
         rsp_ff                 <= rsp_in;
         prev_rtp_ff[slot_idx]  <= req_ff.rtp_timestamp;
         prev_sec_ff[slot_idx]  <= rsp_in.out_sec;
         prev_usec_ff[slot_idx] <= rsp_in.out_usec;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
